>>> rtl/core/amsgrad_pkg.sv
// shared types and constants for the amsgrad adamw parameter update block
// no dependencies

package amsgrad_pkg;

  localparam int SLOTS     = 4096;
  localparam int SLOT_BITS = $clog2(SLOTS);

  localparam logic [2:0] REG_LR    = 3'd0;
  localparam logic [2:0] REG_B1    = 3'd1;
  localparam logic [2:0] REG_B2    = 3'd2;
  localparam logic [2:0] REG_EPS   = 3'd3;
  localparam logic [2:0] REG_DECAY = 3'd4;

  localparam logic [24:0] ONE_Q24 = 25'h100_0000;

  typedef struct packed {
    logic [11:0]        param_index;
    logic signed [31:0] param_value;
    logic signed [31:0] local_gradient;
    logic signed [31:0] activation;
    logic               is_bias;
    logic [19:0]        step_number;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] new_param;
    logic               saturated;
  } out_item_t;

  typedef struct packed {
    logic [SLOT_BITS-1:0] idx;
    logic signed [31:0]   param;
    logic signed [31:0]   grad;
    logic [46:0]          grad_sq;
    logic signed [31:0]   decay_term;
    logic [24:0]          m_pow;
    logic [24:0]          v_pow;
  } work_t;

  typedef struct packed {
    logic [23:0] lr;
    logic [23:0] b1;
    logic [23:0] b2;
    logic [31:0] eps;
    logic [23:0] decay;
  } cfg_t;

endpackage

>>> rtl/core/amsgrad_front.sv
// front end: accepts items, keeps the beta power cache, forms gradient,
// squared gradient and decay term. depends on amsgrad_pkg

module amsgrad_front import amsgrad_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_item_t in_data,
  input  logic     hold,
  input  logic     cache_clr,
  input  cfg_t     cfg,
  input  logic     q_full,
  output logic     q_push,
  output work_t    q_data
);

  localparam logic [2:0] F_IDLE = 3'd0;
  localparam logic [2:0] F_POW  = 3'd1;
  localparam logic [2:0] F_GRAD = 3'd2;
  localparam logic [2:0] F_GVAL = 3'd3;
  localparam logic [2:0] F_GSQ  = 3'd4;
  localparam logic [2:0] F_PUSH = 3'd5;

  logic [2:0]         state_r;
  in_item_t           item_r;
  logic [19:0]        cached_step_r;
  logic [24:0]        p1_r, p2_r;
  logic [4:0]         bit_r;
  logic [1:0]         ph_r;
  logic signed [63:0] prod_r;
  logic signed [56:0] dprod_r;
  logic signed [31:0] g_r, t2_r;
  logic [46:0]        gsq_r;

  logic               accept;
  logic [49:0]        pow_prod;
  logic [24:0]        pow_a, pow_b;
  logic [63:0]        pmag;
  logic [39:0]        pq;
  logic signed [40:0] gfull;
  logic [56:0]        dmag;
  logic [32:0]        dq;
  logic signed [33:0] tfull;
  logic signed [63:0] sq;

  assign in_stall = (state_r != F_IDLE) || hold;
  assign accept   = in_valid && !in_stall;
  assign q_push   = (state_r == F_PUSH) && !q_full;

  always_comb begin
    pow_a = p1_r;
    pow_b = p1_r;
    unique case (ph_r)
      2'd0: begin
        pow_a = p1_r;
        pow_b = p1_r;
      end
      2'd1: begin
        pow_a = p1_r;
        pow_b = {1'b0, cfg.b1};
      end
      2'd2: begin
        pow_a = p2_r;
        pow_b = p2_r;
      end
      2'd3: begin
        pow_a = p2_r;
        pow_b = {1'b0, cfg.b2};
      end
      default: ;
    endcase
    pow_prod = pow_a * pow_b;
  end

  always_comb begin
    pmag  = prod_r[63] ? (64'd0 - prod_r) : prod_r;
    pq    = pmag[63:24];
    gfull = prod_r[63] ? -$signed({1'b0, pq}) : $signed({1'b0, pq});
    dmag  = dprod_r[56] ? (57'd0 - dprod_r) : dprod_r;
    dq    = dmag[56:24];
    tfull = dprod_r[56] ? -$signed({1'b0, dq}) : $signed({1'b0, dq});
    sq    = g_r * g_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= F_IDLE;
      cached_step_r <= '0;
      p1_r          <= '0;
      p2_r          <= '0;
      bit_r         <= '0;
      ph_r          <= '0;
    end else begin
      unique case (state_r)
        F_IDLE: begin
          if (cache_clr) begin
            cached_step_r <= '0;
            p1_r          <= '0;
            p2_r          <= '0;
          end
          if (accept) begin
            item_r <= in_data;
            if (in_data.step_number != cached_step_r) begin
              cached_step_r <= in_data.step_number;
              if (in_data.step_number == 20'd0) begin
                p1_r    <= '0;
                p2_r    <= '0;
                state_r <= F_GRAD;
              end else begin
                p1_r    <= ONE_Q24;
                p2_r    <= ONE_Q24;
                bit_r   <= 5'd19;
                ph_r    <= 2'd0;
                state_r <= F_POW;
              end
            end else begin
              state_r <= F_GRAD;
            end
          end
        end
        F_POW: begin
          unique case (ph_r)
            2'd0: p1_r <= pow_prod[48:24];
            2'd1: if (item_r.step_number[bit_r]) p1_r <= pow_prod[48:24];
            2'd2: p2_r <= pow_prod[48:24];
            2'd3: if (item_r.step_number[bit_r]) p2_r <= pow_prod[48:24];
            default: ;
          endcase
          ph_r <= ph_r + 2'd1;
          if (ph_r == 2'd3) begin
            if (bit_r == 5'd0) state_r <= F_GRAD;
            else bit_r <= bit_r - 5'd1;
          end
        end
        F_GRAD: begin
          prod_r  <= item_r.local_gradient * item_r.activation;
          dprod_r <= $signed({1'b0, cfg.decay}) * item_r.param_value;
          state_r <= F_GVAL;
        end
        F_GVAL: begin
          if (item_r.is_bias) begin
            g_r  <= item_r.local_gradient;
            t2_r <= '0;
          end else begin
            if (gfull > 41'sd2147483647) g_r <= 32'sh7fff_ffff;
            else if (gfull < -41'sd2147483648) g_r <= 32'sh8000_0000;
            else g_r <= gfull[31:0];
            t2_r <= tfull[31:0];
          end
          state_r <= F_GSQ;
        end
        F_GSQ: begin
          gsq_r   <= sq[62:16];
          state_r <= F_PUSH;
        end
        F_PUSH: begin
          if (!q_full) state_r <= F_IDLE;
        end
        default: state_r <= F_IDLE;
      endcase
    end
  end

  always_comb begin
    q_data.idx        = item_r.param_index[SLOT_BITS-1:0];
    q_data.param      = item_r.param_value;
    q_data.grad       = g_r;
    q_data.grad_sq    = gsq_r;
    q_data.decay_term = t2_r;
    q_data.m_pow      = p1_r;
    q_data.v_pow      = p2_r;
  end

endmodule

>>> rtl/core/amsgrad_queue.sv
// two-entry queue of classified items between front and back end
// depends on amsgrad_pkg

module amsgrad_queue import amsgrad_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  work_t push_data,
  input  logic  pop,
  output work_t head,
  output logic  full,
  output logic  empty
);

  work_t      ent_r [2];
  logic       wr_r, rd_r;
  logic [1:0] cnt_r;

  assign full  = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);
  assign head  = ent_r[rd_r];

  always_ff @(posedge clk) begin
    if (push) ent_r[wr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wr_r <= ~wr_r;
      if (pop) rd_r <= ~rd_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

>>> rtl/core/amsgrad_div.sv
// bit-serial restoring divider, one quotient bit a cycle
// no package dependencies

module amsgrad_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [48:0] rem0,
  input  logic [95:0] low,
  input  logic [48:0] den,
  input  logic [6:0]  iters,
  output logic        busy,
  output logic [57:0] quo
);

  logic [48:0] rem_r, den_r;
  logic [95:0] low_r;
  logic [57:0] q_r;
  logic [6:0]  cnt_r;
  logic        busy_r;
  logic [49:0] r2;
  logic        ge;

  assign busy = busy_r;
  assign quo  = q_r;
  assign r2   = {rem_r, low_r[95]};
  assign ge   = (r2 >= {1'b0, den_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= iters;
      rem_r  <= rem0;
      low_r  <= low;
      den_r  <= den;
      q_r    <= '0;
    end else if (busy_r) begin
      rem_r <= ge ? 49'(r2 - {1'b0, den_r}) : r2[48:0];
      q_r   <= {q_r[56:0], ge};
      low_r <= {low_r[94:0], 1'b0};
      cnt_r <= cnt_r - 7'd1;
      if (cnt_r == 7'd1) busy_r <= 1'b0;
    end
  end

endmodule

>>> rtl/core/amsgrad_back.sv
// back end: moment memories, bias correction, peak tracking, square root,
// ratio and final update with output register. depends on amsgrad_pkg, amsgrad_div

module amsgrad_back import amsgrad_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  logic      q_empty,
  input  work_t     q_head,
  output logic      q_pop,
  output logic      clearing,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  localparam logic [4:0] B_IDLE = 5'd0;
  localparam logic [4:0] B_MUL1 = 5'd1;
  localparam logic [4:0] B_MUL2 = 5'd2;
  localparam logic [4:0] B_MUL3 = 5'd3;
  localparam logic [4:0] B_VSUM = 5'd4;
  localparam logic [4:0] B_MDIV = 5'd5;
  localparam logic [4:0] B_VCHK = 5'd6;
  localparam logic [4:0] B_VDIV = 5'd7;
  localparam logic [4:0] B_PEAK = 5'd8;
  localparam logic [4:0] B_SQRT = 5'd9;
  localparam logic [4:0] B_DEN  = 5'd10;
  localparam logic [4:0] B_RCHK = 5'd11;
  localparam logic [4:0] B_RDIV = 5'd12;
  localparam logic [4:0] B_SUM  = 5'd13;
  localparam logic [4:0] B_UPD1 = 5'd14;
  localparam logic [4:0] B_UPD2 = 5'd15;
  localparam logic [4:0] B_OUT  = 5'd16;

  localparam logic [47:0] MAX48     = {48{1'b1}};
  localparam logic [57:0] RATIO_MAX = {58{1'b1}};

  logic [31:0] mom_mem  [SLOTS];
  logic [47:0] var_mem  [SLOTS];
  logic [47:0] peak_mem [SLOTS];

  logic [4:0]           state_r;
  logic [SLOT_BITS:0]   clr_r;
  work_t                wk_r;
  logic [31:0]          m_rd_r;
  logic [47:0]          v_rd_r, p_rd_r;
  logic signed [58:0]   pa_r, pb_r;
  logic signed [31:0]   m_new_r;
  logic [48:0]          lo_r;
  logic [47:0]          v_new_r, vhat_r;
  logic [55:0]          mhat_r;
  logic [63:0]          sq_x_r;
  logic [33:0]          sq_rem_r;
  logic [31:0]          sq_root_r;
  logic [4:0]           sq_cnt_r;
  logic [48:0]          den_r;
  logic [57:0]          ratio_r, smag_r;
  logic [48:0]          acc_r;
  logic                 sneg_r;
  logic                 out_valid_r;
  out_item_t            out_r;

  logic                 rd_en, we;
  logic [SLOT_BITS-1:0] waddr;
  logic [31:0]          m_wd;
  logic [47:0]          v_wd, p_wd, peak_max;
  logic [24:0]          d1, d2;
  logic [25:0]          c1, c2;
  logic signed [59:0]   psum;
  logic [59:0]          psmag;
  logic [33:0]          pq;
  logic signed [34:0]   mfull;
  logic [31:0]          mmag;
  logic [49:0]          vsum;
  logic [35:0]          rem2, trial;
  logic [48:0]          den_c;
  logic signed [59:0]   s_term;
  logic [59:0]          s_mag;
  logic [58:0]          upd;
  logic signed [60:0]   newp;
  logic                 out_free;

  logic                 div_start, div_busy;
  logic [48:0]          div_rem0, div_den;
  logic [95:0]          div_low;
  logic [6:0]           div_iters;
  logic [57:0]          div_q;

  function automatic logic signed [58:0] muls(input logic signed [25:0] a,
                                              input logic signed [32:0] b);
    return a * b;
  endfunction

  assign clearing  = !clr_r[SLOT_BITS];
  assign q_pop     = (state_r == B_IDLE) && !clearing && !q_empty;
  assign rd_en     = q_pop;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign out_free  = !out_valid_r || !out_stall;

  assign d1 = ONE_Q24 - wk_r.m_pow;
  assign d2 = ONE_Q24 - wk_r.v_pow;
  assign c1 = {1'b0, ONE_Q24} - {2'b0, cfg.b1};
  assign c2 = {1'b0, ONE_Q24} - {2'b0, cfg.b2};

  always_comb begin
    psum  = pa_r + pb_r;
    psmag = psum[59] ? (60'd0 - psum) : psum;
    pq    = psmag[57:24];
    mfull = psum[59] ? -$signed({1'b0, pq}) : $signed({1'b0, pq});
    mmag  = m_new_r[31] ? (32'd0 - m_new_r) : m_new_r;
    vsum  = 50'(psum[48:0]) + 50'(lo_r[48:24]);
    peak_max = (vhat_r > p_rd_r) ? vhat_r : p_rd_r;
    rem2  = {sq_rem_r, sq_x_r[63:62]};
    trial = {2'b0, sq_root_r, 2'b01};
    den_c = {1'b0, sq_root_r, 16'd0} + {17'd0, cfg.eps};
    s_term = (m_new_r[31] ? -$signed({2'b0, ratio_r}) : $signed({2'b0, ratio_r}))
             + 60'(wk_r.decay_term);
    s_mag = s_term[59] ? (60'd0 - s_term) : s_term;
    upd   = 59'(acc_r) + {pa_r[34:0], 24'd0};
    if (sneg_r) newp = 61'(wk_r.param) + $signed({2'b0, upd});
    else newp = 61'(wk_r.param) - $signed({2'b0, upd});
  end

  always_comb begin
    div_start = 1'b0;
    div_rem0  = '0;
    div_low   = {mmag, 64'd0};
    div_den   = {24'd0, d1};
    div_iters = 7'd56;
    unique case (state_r)
      B_VSUM: div_start = 1'b1;
      B_VCHK: begin
        div_start = (v_new_r < {d2, 24'd0});
        div_rem0  = {25'd0, v_new_r[47:24]};
        div_low   = {v_new_r[23:0], 72'd0};
        div_den   = {24'd0, d2};
        div_iters = 7'd48;
      end
      B_RCHK: begin
        div_start = !((den_r[48:46] == 3'd0) && ({8'd0, mhat_r} >= {den_r[45:0], 18'd0}));
        div_rem0  = {11'd0, mhat_r[55:18]};
        div_low   = {mhat_r[17:0], 78'd0};
        div_den   = den_r;
        div_iters = 7'd58;
      end
      default: ;
    endcase
  end

  amsgrad_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .rem0  (div_rem0),
    .low   (div_low),
    .den   (div_den),
    .iters (div_iters),
    .busy  (div_busy),
    .quo   (div_q)
  );

  always_comb begin
    we    = clearing || (state_r == B_PEAK);
    waddr = clearing ? clr_r[SLOT_BITS-1:0] : wk_r.idx;
    m_wd  = clearing ? '0 : m_new_r;
    v_wd  = clearing ? '0 : v_new_r;
    p_wd  = clearing ? '0 : peak_max;
  end

  always_ff @(posedge clk) begin
    if (we) mom_mem[waddr] <= m_wd;
    if (rd_en) m_rd_r <= mom_mem[q_head.idx];
  end

  always_ff @(posedge clk) begin
    if (we) var_mem[waddr] <= v_wd;
    if (rd_en) v_rd_r <= var_mem[q_head.idx];
  end

  always_ff @(posedge clk) begin
    if (we) peak_mem[waddr] <= p_wd;
    if (rd_en) p_rd_r <= peak_mem[q_head.idx];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (clearing) clr_r <= clr_r + 1'b1;
      if ((state_r == B_OUT) && out_free) out_valid_r <= 1'b1;
      else if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      unique case (state_r)
        B_IDLE: begin
          if (q_pop) begin
            wk_r    <= q_head;
            state_r <= B_MUL1;
          end
        end
        B_MUL1: begin
          pa_r    <= muls($signed({2'b0, cfg.b1}), 33'(signed'(m_rd_r)));
          pb_r    <= muls($signed(c1), 33'(wk_r.grad));
          state_r <= B_MUL2;
        end
        B_MUL2: begin
          m_new_r <= mfull[31:0];
          pa_r    <= muls($signed({2'b0, cfg.b2}), $signed({9'd0, v_rd_r[23:0]}));
          pb_r    <= muls($signed(c2), $signed({9'd0, wk_r.grad_sq[23:0]}));
          state_r <= B_MUL3;
        end
        B_MUL3: begin
          lo_r    <= psum[48:0];
          pa_r    <= muls($signed({2'b0, cfg.b2}), $signed({9'd0, v_rd_r[47:24]}));
          pb_r    <= muls($signed(c2), $signed({10'd0, wk_r.grad_sq[46:24]}));
          state_r <= B_VSUM;
        end
        B_VSUM: begin
          v_new_r <= vsum[47:0];
          state_r <= B_MDIV;
        end
        B_MDIV: begin
          if (!div_busy) begin
            mhat_r  <= div_q[55:0];
            state_r <= B_VCHK;
          end
        end
        B_VCHK: begin
          if (div_start) begin
            state_r <= B_VDIV;
          end else begin
            vhat_r  <= MAX48;
            state_r <= B_PEAK;
          end
        end
        B_VDIV: begin
          if (!div_busy) begin
            vhat_r  <= div_q[47:0];
            state_r <= B_PEAK;
          end
        end
        B_PEAK: begin
          sq_x_r    <= {peak_max, 16'd0};
          sq_rem_r  <= '0;
          sq_root_r <= '0;
          sq_cnt_r  <= '0;
          state_r   <= B_SQRT;
        end
        B_SQRT: begin
          if (rem2 >= trial) begin
            sq_rem_r  <= 34'(rem2 - trial);
            sq_root_r <= {sq_root_r[30:0], 1'b1};
          end else begin
            sq_rem_r  <= rem2[33:0];
            sq_root_r <= {sq_root_r[30:0], 1'b0};
          end
          sq_x_r   <= {sq_x_r[61:0], 2'b00};
          sq_cnt_r <= sq_cnt_r + 5'd1;
          if (sq_cnt_r == 5'd31) state_r <= B_DEN;
        end
        B_DEN: begin
          den_r   <= (den_c == 49'd0) ? 49'd1 : den_c;
          state_r <= B_RCHK;
        end
        B_RCHK: begin
          if (div_start) begin
            state_r <= B_RDIV;
          end else begin
            ratio_r <= RATIO_MAX;
            state_r <= B_SUM;
          end
        end
        B_RDIV: begin
          if (!div_busy) begin
            ratio_r <= div_q;
            state_r <= B_SUM;
          end
        end
        B_SUM: begin
          sneg_r  <= s_term[59];
          smag_r  <= (s_mag > {2'b0, RATIO_MAX}) ? RATIO_MAX : s_mag[57:0];
          state_r <= B_UPD1;
        end
        B_UPD1: begin
          pa_r    <= muls($signed({2'b0, cfg.lr}), $signed({9'd0, smag_r[23:0]}));
          pb_r    <= muls($signed({2'b0, cfg.lr}), $signed({9'd0, smag_r[47:24]}));
          state_r <= B_UPD2;
        end
        B_UPD2: begin
          acc_r   <= pb_r[48:0] + {24'd0, pa_r[48:24]};
          pa_r    <= muls($signed({2'b0, cfg.lr}), $signed({23'd0, smag_r[57:48]}));
          state_r <= B_OUT;
        end
        B_OUT: begin
          if (out_free) begin
            if (newp > 61'sd2147483647) begin
              out_r.new_param <= 32'sh7fff_ffff;
              out_r.saturated <= 1'b1;
            end else if (newp < -61'sd2147483648) begin
              out_r.new_param <= 32'sh8000_0000;
              out_r.saturated <= 1'b1;
            end else begin
              out_r.new_param <= newp[31:0];
              out_r.saturated <= 1'b0;
            end
            state_r <= B_IDLE;
          end
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end

endmodule

>>> rtl/core/amsgrad_adamw_param_update.sv
// top level: register file, front end, queue and back end
// a change to a nonzero step number recomputes the beta power cache; a saturating
// corrected variance or ratio skips its division. the back end takes one item at a
// time through the bit-serial divider (56, 48 and 58 bits) and the 32-step square
// root while the front end and queue take more; a stalled result holds the back end
// after reset a clearing pass zeroes all 4096 slots of the memories with in_stall high

module amsgrad_adamw_param_update import amsgrad_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t       cfg_r;
  logic       wr_en, cache_clr, clearing;
  logic [2:0] reg_idx;
  logic       q_push, q_pop, q_full, q_empty;
  work_t      q_in, q_head;

  assign pready    = 1'b1;
  assign reg_idx   = paddr[4:2];
  assign wr_en     = psel && penable && pwrite && pready;
  assign cache_clr = wr_en && ((reg_idx == REG_B1) || (reg_idx == REG_B2));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.lr    <= 24'd16777;
      cfg_r.b1    <= 24'd15099494;
      cfg_r.b2    <= 24'd16760438;
      cfg_r.eps   <= 32'd10995;
      cfg_r.decay <= 24'd167772;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_LR:    cfg_r.lr    <= pwdata[23:0];
        REG_B1:    cfg_r.b1    <= pwdata[23:0];
        REG_B2:    cfg_r.b2    <= pwdata[23:0];
        REG_EPS:   cfg_r.eps   <= pwdata;
        REG_DECAY: cfg_r.decay <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_LR:    prdata = {8'd0, cfg_r.lr};
      REG_B1:    prdata = {8'd0, cfg_r.b1};
      REG_B2:    prdata = {8'd0, cfg_r.b2};
      REG_EPS:   prdata = cfg_r.eps;
      REG_DECAY: prdata = {8'd0, cfg_r.decay};
      default:   prdata = '0;
    endcase
  end

  amsgrad_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .hold      (clearing),
    .cache_clr (cache_clr),
    .cfg       (cfg_r),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (q_in)
  );

  amsgrad_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .head      (q_head),
    .full      (q_full),
    .empty     (q_empty)
  );

  amsgrad_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .clearing  (clearing),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

>>> rtl/core/amsgrad_checker.sv
// port-level checks for the amsgrad adamw parameter update block
// depends on amsgrad_pkg; bound to amsgrad_adamw_param_update

module amsgrad_checker import amsgrad_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input out_item_t   out_data,
  input logic        psel,
  input logic        penable,
  input logic        pwrite,
  input logic [4:0]  paddr,
  input logic [31:0] pwdata,
  input logic [31:0] prdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result item dropped while stalled");

  a_reset_stall: assert property (@(posedge clk)
    !rst_n |=> in_stall)
    else $error("input taken during clearing pass");

  a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.saturated |->
      (out_data.new_param == 32'sh7fff_ffff || out_data.new_param == 32'sh8000_0000))
    else $error("saturated flag without limit value");

  a_lr_readback: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $past(psel && penable && pwrite && paddr[4:2] == REG_LR)
      && paddr[4:2] == REG_LR |-> prdata == {8'd0, $past(pwdata[23:0])})
    else $error("learning rate readback mismatch");

endmodule

bind amsgrad_adamw_param_update amsgrad_checker u_checker (.*);
